@@ rtl/csc_pkg.sv @@
package csc_pkg;

   // request kinds
   localparam logic [1:0] KIND_TRANSITION = 2'd0;
   localparam logic [1:0] KIND_RESET      = 2'd1;
   localparam logic [1:0] KIND_TICK       = 2'd2;

   // result event codes
   localparam logic [1:0] EV_TAKEN    = 2'd0;
   localparam logic [1:0] EV_REJECTED = 2'd1;
   localparam logic [1:0] EV_RESET    = 2'd2;
   localparam logic [1:0] EV_TIMEOUT  = 2'd3;

   // call state codes
   localparam logic [3:0] ST_IDLE          = 4'd0;
   localparam logic [3:0] ST_OUTGOING      = 4'd1;
   localparam logic [3:0] ST_RINGING       = 4'd2;
   localparam logic [3:0] ST_INCOMING      = 4'd3;
   localparam logic [3:0] ST_CONNECTING    = 4'd4;
   localparam logic [3:0] ST_ACTIVE        = 4'd5;
   localparam logic [3:0] ST_HELD          = 4'd6;
   localparam logic [3:0] ST_DISCONNECTING = 4'd7;
   localparam logic [3:0] ST_FAILED        = 4'd8;

   localparam logic [9:0]  STATUS_MAX      = 10'd999;
   localparam logic [15:0] TIMEOUT_RESET   = 16'd30000;
   localparam logic [15:0] ELAPSED_MAX     = 16'hFFFF;

   // csr map
   localparam int          CSR_ADDR_W      = 3;
   localparam int          CSR_DATA_W      = 32;
   localparam logic [0:0]  REG_TIMEOUT_MS  = 1'b0;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] target_state;
      logic [9:0] status_in;
   } req_type;

   typedef struct packed {
      logic [1:0] event_res;
      logic [3:0] prior_state;
      logic [3:0] current_state;
      logic [3:0] asked_state;
      logic [9:0] status_out;
   } rsp_type;

   // result handed from the engine to the output register
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

   // allowed moves: bit t of the row for state f is set when f -> t is legal
   function automatic logic [8:0] allowed_moves(input logic [3:0] from_state);
      logic [8:0] row;
      row = 9'h000;
      unique case (from_state)
         ST_IDLE:          row = 9'h00A;
         ST_OUTGOING:      row = 9'h194;
         ST_RINGING:       row = 9'h1B0;
         ST_INCOMING:      row = 9'h1B1;
         ST_CONNECTING:    row = 9'h120;
         ST_ACTIVE:        row = 9'h1C0;
         ST_HELD:          row = 9'h0A0;
         ST_DISCONNECTING: row = 9'h101;
         ST_FAILED:        row = 9'h001;
         default:          row = 9'h000;
      endcase
      return row;
   endfunction

endpackage

@@ rtl/csc_csr.sv @@
module csc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [csc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [csc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [csc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output logic [15:0]                     timeout_ms
);
   import csc_pkg::*;

   logic [15:0] timeout_ms_ff;
   logic [15:0] timeout_ms_in;
   logic        sel_timeout;
   logic        wr_en;

   // word index of the register
   assign sel_timeout = (csr_paddr[CSR_ADDR_W-1:2] == REG_TIMEOUT_MS);
   assign wr_en       = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign timeout_ms_in = (wr_en && sel_timeout) ? csr_pwdata[15:0] : timeout_ms_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ms_ff <= TIMEOUT_RESET;
      end else begin
         timeout_ms_ff <= timeout_ms_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = sel_timeout ? {{(CSR_DATA_W-16){1'b0}}, timeout_ms_ff}
                                   : '0;
   assign timeout_ms = timeout_ms_ff;

endmodule

@@ rtl/csc_engine.sv @@
module csc_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  csc_pkg::req_type    req_data,
   input  logic [15:0]         timeout_ms,
   input  logic                out_free,
   output csc_pkg::result_type result
);
   import csc_pkg::*;

   // input register
   logic        in_valid_ff, in_valid_in;
   req_type     in_req_ff, in_req_in;

   // call state
   logic [3:0]  call_state_ff, call_state_in;
   logic [9:0]  stored_status_ff, stored_status_in;
   logic        timer_armed_ff, timer_armed_in;
   logic [15:0] elapsed_ms_ff, elapsed_ms_in;

   logic        advance;
   logic [8:0]  move_row;
   logic        move_ok;
   logic [15:0] elapsed_inc;
   logic [3:0]  fallback;
   logic [9:0]  status_sat;

   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   assign in_valid_in = req_stall ? 1'b1 : req_valid;
   assign in_req_in   = req_stall ? in_req_ff : req_data;

   assign move_row    = allowed_moves(call_state_ff);
   assign move_ok     = (in_req_ff.target_state <= ST_FAILED) &&
                        move_row[in_req_ff.target_state[3:0] & 4'hF];
   assign elapsed_inc = (elapsed_ms_ff != ELAPSED_MAX) ? elapsed_ms_ff + 16'd1
                                                       : elapsed_ms_ff;
   assign fallback    = (call_state_ff == ST_DISCONNECTING) ? ST_IDLE : ST_FAILED;
   assign status_sat  = (in_req_ff.status_in > STATUS_MAX) ? STATUS_MAX
                                                           : in_req_ff.status_in;

   always_comb begin
      call_state_in    = call_state_ff;
      stored_status_in = stored_status_ff;
      timer_armed_in   = timer_armed_ff;
      elapsed_ms_in    = elapsed_ms_ff;
      result.valid              = 1'b0;
      result.data.event_res     = EV_REJECTED;
      result.data.prior_state   = call_state_ff;
      result.data.current_state = call_state_ff;
      result.data.asked_state   = in_req_ff.target_state;
      result.data.status_out    = stored_status_ff;
      if (advance) begin
         unique case (in_req_ff.kind)
            KIND_TRANSITION: begin
               result.valid = 1'b1;
               if (move_ok) begin
                  call_state_in    = in_req_ff.target_state;
                  stored_status_in = status_sat;
                  timer_armed_in   = (in_req_ff.target_state == ST_OUTGOING) ||
                                     (in_req_ff.target_state == ST_DISCONNECTING);
                  elapsed_ms_in    = '0;
                  result.data.event_res     = EV_TAKEN;
                  result.data.current_state = in_req_ff.target_state;
                  result.data.status_out    = status_sat;
               end
            end
            KIND_RESET: begin
               call_state_in    = ST_IDLE;
               stored_status_in = '0;
               timer_armed_in   = 1'b0;
               elapsed_ms_in    = '0;
               result.valid              = 1'b1;
               result.data.event_res     = EV_RESET;
               result.data.current_state = ST_IDLE;
               result.data.asked_state   = ST_IDLE;
               result.data.status_out    = '0;
            end
            KIND_TICK: begin
               if (timer_armed_ff) begin
                  if (elapsed_inc >= timeout_ms) begin
                     call_state_in    = fallback;
                     stored_status_in = '0;
                     timer_armed_in   = 1'b0;
                     elapsed_ms_in    = '0;
                     result.valid              = 1'b1;
                     result.data.event_res     = EV_TIMEOUT;
                     result.data.current_state = fallback;
                     result.data.asked_state   = fallback;
                     result.data.status_out    = '0;
                  end else begin
                     elapsed_ms_in = elapsed_inc;
                  end
               end
            end
            default: begin
               // unused kind: dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         call_state_ff    <= ST_IDLE;
         stored_status_ff <= '0;
         timer_armed_ff   <= 1'b0;
         elapsed_ms_ff    <= '0;
      end else begin
         in_valid_ff      <= in_valid_in;
         call_state_ff    <= call_state_in;
         stored_status_ff <= stored_status_in;
         timer_armed_ff   <= timer_armed_in;
         elapsed_ms_ff    <= elapsed_ms_in;
      end
   end

   always_ff @(posedge clock) begin
      in_req_ff <= in_req_in;
   end

endmodule

@@ rtl/csc_rsp_reg.sv @@
module csc_rsp_reg (
   input  logic                clock,
   input  logic                reset,
   input  csc_pkg::result_type result,
   output logic                out_free,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output csc_pkg::rsp_type    rsp_data
);
   import csc_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    load;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load     = result.valid && out_free;

   assign rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = load ? result.data : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/call_state_controller.sv @@
// call state controller
//
// request channel (req_valid / req_stall / req_data): one request per cycle while req_stall is low,
// kind selects a state transition, a reset to idle or a one millisecond tick
// result channel (rsp_valid / rsp_stall / rsp_data): zero or one result per
// request, in request order; ticks that do not expire the timer give none
// csr port: one register, timeout_ms at byte address 0, written in the
// access phase (psel, penable and pwrite high), pready tied high
//
// path: an accepted request lands in the input register, is evaluated
// against the transition table and the timer, and its result is loaded
// into the result register and shown on rsp_*
// throughput: one request per cycle while rsp_stall does not hold the
// result register; the single evaluation stage updates the call state
//
// reset: state idle, status 0, timer stopped, timeout_ms back to 30000,
// both pipeline registers empty
// receiver stall: the result register holds; the evaluation stage waits, and
// the input register keeps its request, so req_stall rises in the same cycle
module call_state_controller (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  csc_pkg::req_type                req_data,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output csc_pkg::rsp_type                rsp_data,
   // configuration
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [csc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [csc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [csc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import csc_pkg::*;

   logic        [15:0] timeout_ms;
   logic               out_free;
   result_type         result;

   // timeout register
   csc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .timeout_ms  (timeout_ms)
   );

   // input register, transition check and timer
   csc_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .timeout_ms (timeout_ms),
      .out_free   (out_free),
      .result     (result)
   );

   // result register
   csc_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/csc_checker.sv @@
module csc_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input csc_pkg::rsp_type rsp_data
);
   import csc_pkg::*;

   // state shown by the last delivered result
   logic [3:0] last_state_ff;
   logic [3:0] last_state_in;
   logic       rsp_take;

   assign rsp_take      = rsp_valid && !rsp_stall;
   assign last_state_in = rsp_take ? rsp_data.current_state : last_state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_state_ff <= ST_IDLE;
      end else begin
         last_state_ff <= last_state_in;
      end
   end

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

   // every state change is reported, so results chain state to state
   a_state_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.prior_state == last_state_ff))
      else $error("result prior state breaks the chain");

   // a timeout falls back to idle from disconnecting, else to failed
   a_timeout_fallback: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.event_res == EV_TIMEOUT) |->
      (rsp_data.current_state == rsp_data.asked_state &&
       rsp_data.status_out == 10'd0 &&
       ((rsp_data.prior_state == ST_DISCONNECTING && rsp_data.current_state == ST_IDLE) ||
        (rsp_data.prior_state != ST_DISCONNECTING && rsp_data.current_state == ST_FAILED))))
      else $error("bad timeout fallback");

   // a rejected request leaves the state alone
   a_reject_keeps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.event_res == EV_REJECTED) |->
      (rsp_data.current_state == rsp_data.prior_state))
      else $error("rejected request changed state");

endmodule

bind call_state_controller csc_checker u_csc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
